@@ rtl/mtb_pkg.sv @@
// Package for the timer bank: sizes, command and result codes, and the
// types shared by the front end, the op queue and the back end.
// Depends on nothing.
`timescale 1ns / 1ps

package mtb_pkg;

    // Number of timers in the bank (1 to 64).
    localparam int TIMER_COUNT = 16;
    // Most results that one tick may report.
    localparam int MAX_RESULTS = 16;

    localparam int ID_W      = 16;
    localparam int TIMEOUT_W = 32;
    localparam int COUNT_W   = 32;
    localparam int REM_W     = TIMEOUT_W + 1;
    localparam int IDX_W     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int STAMP_W   = $clog2(TIMER_COUNT + 1);
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    // The op queue depth must be a power of two so that the pointers wrap.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_OK      = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET,
        OP_CANCEL,
        OP_QUERY,
        OP_INVALID
    } op_kind_t;

    typedef struct packed {
        op_kind_t               op;
        logic [ID_W-1:0]        id;
        logic [TIMEOUT_W-1:0]   timeout;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

endpackage

@@ rtl/mtb_req_if.sv @@
// Request channel of the timer bank: valid/ready handshake with the
// command, timer id and timeout of one item. Depends on mtb_pkg.
`timescale 1ns / 1ps

interface mtb_req_if;
    import mtb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [ID_W-1:0]        timer_id;
    logic [TIMEOUT_W-1:0]   timeout;

    modport source (output valid, cmd, timer_id, timeout, input ready);
    modport sink   (input valid, cmd, timer_id, timeout, output ready);
endinterface

@@ rtl/mtb_rsp_if.sv @@
// Result channel of the timer bank: valid/ready handshake with the fields
// of one result item. Depends on mtb_pkg.
`timescale 1ns / 1ps

interface mtb_rsp_if;
    import mtb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [ID_W-1:0]        timer_index;
    logic [COUNT_W-1:0]     expiry_count;
    logic                   armed;
    logic                   last;

    modport source (output valid, kind, timer_index, expiry_count, armed, last,
                    input ready);
    modport sink   (input valid, kind, timer_index, expiry_count, armed, last,
                    output ready);
endinterface

@@ rtl/mtb_front.sv @@
// Front end of the timer bank: takes request items, decodes them into ops
// (flagging out-of-range ids) and pushes them into the op queue.
// Depends on mtb_pkg and mtb_req_if.
`timescale 1ns / 1ps

module mtb_front (
    input  logic            clk,
    input  logic            rst_n,
    mtb_req_if.sink         req,
    input  mtb_pkg::q_stat_t stat,
    output logic            push,
    output mtb_pkg::op_t    push_data
);
    import mtb_pkg::*;

    logic   valid_reg;
    op_t    op_reg;
    op_t    op_next;

    assign push      = valid_reg && !stat.full;
    assign push_data = op_reg;
    assign req.ready = !valid_reg || push;

    always_comb
    begin
        op_next.id      = req.timer_id;
        op_next.timeout = req.timeout;
        case (cmd_t'(req.cmd))
            CMD_TICK:   op_next.op = OP_TICK;
            CMD_SET:    op_next.op = OP_SET;
            CMD_CANCEL: op_next.op = OP_CANCEL;
            CMD_QUERY:  op_next.op = OP_QUERY;
            default:    op_next.op = OP_TICK;
        endcase
        if (cmd_t'(req.cmd) != CMD_TICK && req.timer_id >= ID_W'(TIMER_COUNT))
        begin
            op_next.op = OP_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg <= op_next;
        end
    end

endmodule

@@ rtl/mtb_queue.sv @@
// Short FIFO of decoded ops between the front end and the back end.
// Depends on mtb_pkg.
`timescale 1ns / 1ps

module mtb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mtb_pkg::op_t     push_data,
    input  logic             pop,
    output mtb_pkg::op_t     head,
    output mtb_pkg::q_stat_t stat
);
    import mtb_pkg::*;

    op_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/mtb_back.sv @@
// Back end of the timer bank: holds the timer state, carries out ops from
// the queue, scans expiries on a tick (held-over ones first, then in set
// order) and drives the result register. Depends on mtb_pkg and mtb_rsp_if.
`timescale 1ns / 1ps

module mtb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mtb_pkg::op_t     head,
    input  mtb_pkg::q_stat_t stat,
    output logic             pop,
    mtb_rsp_if.source        rsp
);
    import mtb_pkg::*;

    // Timer state. The rank of an armed timer among armed timers in set
    // order is kept in stamp_reg; ranks close up when a timer is disarmed.
    logic [TIMER_COUNT-1:0] armed_reg;
    logic [TIMER_COUNT-1:0] armed_next;
    logic [REM_W-1:0]       rem_reg     [TIMER_COUNT];
    logic [REM_W-1:0]       rem_next    [TIMER_COUNT];
    logic [COUNT_W-1:0]     expcnt_reg  [TIMER_COUNT];
    logic [COUNT_W-1:0]     expcnt_next [TIMER_COUNT];
    logic [STAMP_W-1:0]     stamp_reg   [TIMER_COUNT];
    logic [STAMP_W-1:0]     stamp_next  [TIMER_COUNT];
    logic [STAMP_W-1:0]     stamp_cnt_reg;
    logic [STAMP_W-1:0]     stamp_cnt_next;

    // Tick scan state.
    back_state_t            state_reg;
    back_state_t            state_next;
    logic [TIMER_COUNT-1:0] cand_reg;
    logic [TIMER_COUNT-1:0] cand_next;
    logic [TIMER_COUNT-1:0] over_reg;
    logic [TIMER_COUNT-1:0] over_next;
    logic                   pass_over_reg;
    logic                   pass_over_next;
    logic [STAMP_W-1:0]     rank_reg;
    logic [STAMP_W-1:0]     rank_next;
    logic [RES_CNT_W-1:0]   res_cnt_reg;
    logic [RES_CNT_W-1:0]   res_cnt_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    kind_t                  out_kind_reg;
    kind_t                  out_kind_next;
    logic [ID_W-1:0]        out_index_reg;
    logic [ID_W-1:0]        out_index_next;
    logic [COUNT_W-1:0]     out_count_reg;
    logic [COUNT_W-1:0]     out_count_next;
    logic                   out_armed_reg;
    logic                   out_armed_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic                   out_free;
    logic [IDX_W-1:0]       tidx;
    logic [TIMER_COUNT-1:0] tick_cand;
    logic [TIMER_COUNT-1:0] tick_over;
    logic [TIMER_COUNT-1:0] match;
    logic [TIMER_COUNT-1:0] scan_vec;
    logic [TIMER_COUNT-1:0] hit_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   scan_last;
    logic [COUNT_W-1:0]     exp_cur;
    logic [COUNT_W-1:0]     exp_inc;
    logic                   dis_en;
    logic [IDX_W-1:0]       dis_idx;

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.timer_index  = out_index_reg;
    assign rsp.expiry_count = out_count_reg;
    assign rsp.armed        = out_armed_reg;
    assign rsp.last         = out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign tidx     = head.id[IDX_W-1:0];

    // A timer is due on this tick when at most one tick remains; one with
    // none left was held over from a tick that hit the result limit.
    always_comb
    begin
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            tick_cand[i] = armed_reg[i] && (rem_reg[i][REM_W-1:1] == '0);
            tick_over[i] = armed_reg[i] && (rem_reg[i] == '0);
        end
    end

    // Find the armed timer holding the current rank among the candidates
    // of the running pass.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            match[i] = armed_reg[i] && (stamp_reg[i] == rank_reg);
        end
        scan_vec = cand_reg & (pass_over_reg ? over_reg : ~over_reg);
        hit_vec  = match & scan_vec;
        hit      = |hit_vec;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        scan_last = (res_cnt_reg == RES_CNT_W'(MAX_RESULTS - 1))
                    || !(|(cand_reg & ~hit_vec));
        exp_cur   = expcnt_reg[hit_idx];
        exp_inc   = (exp_cur == '1) ? exp_cur : exp_cur + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        rem_next       = rem_reg;
        expcnt_next    = expcnt_reg;
        stamp_next     = stamp_reg;
        stamp_cnt_next = stamp_cnt_reg;
        cand_next      = cand_reg;
        over_next      = over_reg;
        pass_over_next = pass_over_reg;
        rank_next      = rank_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_armed_next = out_armed_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        dis_en         = 1'b0;
        dis_idx        = hit_idx;

        case (state_reg)
            BK_IDLE:
            begin
                if (!stat.empty)
                begin
                    case (head.op)
                        OP_TICK:
                        begin
                            pop            = 1'b1;
                            cand_next      = tick_cand;
                            over_next      = tick_over;
                            pass_over_next = |tick_over;
                            rank_next      = '0;
                            res_cnt_next   = '0;
                            for (int i = 0; i < TIMER_COUNT; i++)
                            begin
                                if (armed_reg[i] && rem_reg[i] != '0)
                                begin
                                    rem_next[i] = rem_reg[i] - 1'b1;
                                end
                            end
                            if (|tick_cand)
                            begin
                                state_next = BK_SCAN;
                            end
                        end
                        OP_INVALID:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_INVALID;
                                out_index_next = head.id;
                                out_count_next = '0;
                                out_armed_next = 1'b0;
                                out_last_next  = 1'b1;
                            end
                        end
                        OP_SET:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_index_next = head.id;
                                out_count_next = expcnt_reg[tidx];
                                out_armed_next = 1'b1;
                                out_last_next  = 1'b1;
                                if (armed_reg[tidx])
                                begin
                                    out_kind_next = KIND_INVALID;
                                end
                                else
                                begin
                                    out_kind_next    = KIND_OK;
                                    armed_next[tidx] = 1'b1;
                                    rem_next[tidx]   = REM_W'(head.timeout) + 1'b1;
                                    stamp_next[tidx] = stamp_cnt_reg;
                                    stamp_cnt_next   = stamp_cnt_reg + 1'b1;
                                end
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_index_next = head.id;
                                out_count_next = expcnt_reg[tidx];
                                out_armed_next = 1'b0;
                                out_last_next  = 1'b1;
                                if (armed_reg[tidx])
                                begin
                                    out_kind_next = KIND_OK;
                                    dis_en        = 1'b1;
                                    dis_idx       = tidx;
                                end
                                else
                                begin
                                    out_kind_next = KIND_INVALID;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_OK;
                                out_index_next = head.id;
                                out_count_next = expcnt_reg[tidx];
                                out_armed_next = armed_reg[tidx];
                                out_last_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (!(|scan_vec))
                begin
                    // Held-over timers are done; restart for the newly due ones.
                    pass_over_next = 1'b0;
                    rank_next      = '0;
                end
                else if (!hit)
                begin
                    rank_next = rank_reg + 1'b1;
                end
                else if (out_free)
                begin
                    // Expiring this timer closes up the ranks above it, so the
                    // rank pointer stays where it is.
                    cand_next             = cand_reg & ~hit_vec;
                    expcnt_next[hit_idx]  = exp_inc;
                    dis_en                = 1'b1;
                    dis_idx               = hit_idx;
                    res_cnt_next          = res_cnt_reg + 1'b1;
                    out_valid_next        = 1'b1;
                    out_kind_next         = KIND_EXPIRED;
                    out_index_next        = ID_W'(hit_idx);
                    out_count_next        = exp_inc;
                    out_armed_next        = 1'b0;
                    out_last_next         = scan_last;
                    if (scan_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (dis_en)
        begin
            for (int j = 0; j < TIMER_COUNT; j++)
            begin
                if (armed_reg[j] && IDX_W'(j) != dis_idx
                    && stamp_reg[j] > stamp_reg[dis_idx])
                begin
                    stamp_next[j] = stamp_reg[j] - 1'b1;
                end
            end
            armed_next[dis_idx] = 1'b0;
            if (stamp_cnt_reg != '0)
            begin
                stamp_cnt_next = stamp_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            armed_reg     <= '0;
            stamp_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                expcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            stamp_cnt_reg <= stamp_cnt_next;
            out_valid_reg <= out_valid_next;
            expcnt_reg    <= expcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        stamp_reg     <= stamp_next;
        cand_reg      <= cand_next;
        over_reg      <= over_next;
        pass_over_reg <= pass_over_next;
        rank_reg      <= rank_next;
        res_cnt_reg   <= res_cnt_next;
        out_kind_reg  <= out_kind_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
        out_armed_reg <= out_armed_next;
        out_last_reg  <= out_last_next;
    end

endmodule

@@ rtl/multi_timer_bank_unit.sv @@
// Top level of the timer bank: front end, op queue and back end.
// Depends on mtb_pkg, mtb_req_if, mtb_rsp_if, mtb_front, mtb_queue, mtb_back.
`timescale 1ns / 1ps

// A bank of TIMER_COUNT one-shot timers. Set, cancel and query items each
// give one result; a tick gives one result per expired timer (none on a
// quiet tick), earliest deadline first and in set order among equals, with
// last marking the final result of an item. A request passes a decode
// register and a two-entry op queue before the execution unit, so requests
// keep flowing while results wait on rsp.ready until the queue fills. Set,
// cancel and query are carried out once the result register is free. A tick
// first ages all timers and then walks the set-order ranks, giving one expiry
// per due timer and waiting whenever the result channel stalls; held-over
// timers get a pass of their own ahead of the newly due ones.
// No clearing pass follows reset.
module multi_timer_bank_unit (
    input  logic    clk,
    input  logic    rst_n,
    mtb_req_if.sink   req,
    mtb_rsp_if.source rsp
);
    import mtb_pkg::*;

    logic       push;
    op_t        push_data;
    logic       pop;
    op_t        head;
    q_stat_t    stat;

    mtb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    mtb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    mtb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .stat  (stat),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

@@ dv/timer_bank_monitor.sv @@
// Monitor for the timer bank: watches the request and result channels,
// keeps its own copy of the timers and checks every result in order.
// Depends on mtb_pkg, mtb_req_if and mtb_rsp_if.
`timescale 1ns / 1ps

module timer_bank_monitor (
    input  logic clk,
    input  logic rst_n,
    mtb_req_if   req,
    mtb_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);
    import mtb_pkg::*;

    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      timer_index;
        logic [COUNT_W-1:0]   expiry_count;
        logic                 armed;
        logic                 last;
    } bank_result_t;

    logic [REM_W-1:0]   ticks_left [TIMER_COUNT];
    logic               is_armed   [TIMER_COUNT];
    logic [COUNT_W-1:0] fire_count [TIMER_COUNT];
    logic [7:0]         set_rank   [TIMER_COUNT];
    logic [7:0]         armed_total;

    bank_result_t expected_results [$];

    function automatic bank_result_t make_result(kind_t k, logic [ID_W-1:0] idx,
                                                 logic [COUNT_W-1:0] cnt, logic arm,
                                                 logic fin);
        bank_result_t r;
        r.kind         = k;
        r.timer_index  = idx;
        r.expiry_count = cnt;
        r.armed        = arm;
        r.last         = fin;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Timers armed later than the one leaving move up one rank.
    task automatic disarm_timer(int t);
        logic [7:0] rank;
        rank = set_rank[t];
        for (int j = 0; j < TIMER_COUNT; j++)
        begin
            if (j != t && is_armed[j] && set_rank[j] > rank)
                set_rank[j] = set_rank[j] - 8'd1;
        end
        is_armed[t]   = 1'b0;
        ticks_left[t] = '0;
        set_rank[t]   = '0;
        if (armed_total != 0)
            armed_total = armed_total - 8'd1;
    endtask

    task automatic expire_due_timers();
        logic         due  [TIMER_COUNT];
        logic         late [TIMER_COUNT];
        bank_result_t fired [MAX_RESULTS];
        int           best;
        int           n;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            due[i]  = is_armed[i] && (ticks_left[i] <= REM_W'(1));
            late[i] = is_armed[i] && (ticks_left[i] == '0);
            if (is_armed[i] && ticks_left[i] != '0)
                ticks_left[i] = ticks_left[i] - REM_W'(1);
        end
        // Held-over timers go first; otherwise the oldest set wins.
        n = 0;
        while (n < MAX_RESULTS)
        begin
            best = -1;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                if (due[i])
                begin
                    if (best < 0)
                        best = i;
                    else if ((late[i] && !late[best]) ||
                             (late[i] == late[best] && set_rank[i] < set_rank[best]))
                        best = i;
                end
            end
            if (best < 0)
                break;
            due[best] = 1'b0;
            if (fire_count[best] != '1)
                fire_count[best] = fire_count[best] + COUNT_W'(1);
            disarm_timer(best);
            fired[n] = make_result(KIND_EXPIRED, ID_W'(best), fire_count[best], 1'b0, 1'b0);
            n++;
        end
        for (int j = 0; j < n; j++)
        begin
            if (j == n - 1)
                fired[j].last = 1'b1;
            expected_results.push_back(fired[j]);
        end
    endtask

    task automatic apply_request(cmd_t c, logic [ID_W-1:0] id, logic [TIMEOUT_W-1:0] to);
        int    t;
        kind_t k;
        if (c == CMD_TICK)
            expire_due_timers();
        else if (id >= TIMER_COUNT)
            expected_results.push_back(make_result(KIND_INVALID, id, '0, 1'b0, 1'b1));
        else
        begin
            t = int'(id);
            k = KIND_OK;
            if (c == CMD_SET)
            begin
                if (is_armed[t])
                    k = KIND_INVALID;
                else
                begin
                    is_armed[t]   = 1'b1;
                    ticks_left[t] = {1'b0, to} + REM_W'(1);
                    set_rank[t]   = armed_total;
                    armed_total   = armed_total + 8'd1;
                end
            end
            else if (c == CMD_CANCEL)
            begin
                if (!is_armed[t])
                    k = KIND_INVALID;
                else
                    disarm_timer(t);
            end
            expected_results.push_back(make_result(k, id, fire_count[t], is_armed[t], 1'b1));
        end
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result();
        bank_result_t want;
        if (expected_results.size() == 0)
            report_error($sformatf("unexpected result item: kind %0d timer %0d",
                                   rsp.kind, rsp.timer_index));
        else
        begin
            want = expected_results.pop_front();
            check_field("kind", 64'(rsp.kind), 64'(want.kind));
            check_field("timer_index", 64'(rsp.timer_index), 64'(want.timer_index));
            check_field("expiry_count", 64'(rsp.expiry_count), 64'(want.expiry_count));
            check_field("armed", 64'(rsp.armed), 64'(want.armed));
            check_field("last", 64'(rsp.last), 64'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                ticks_left[i] = '0;
                is_armed[i]   = 1'b0;
                fire_count[i] = '0;
                set_rank[i]   = '0;
            end
            armed_total = '0;
            expected_results.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            // A request item is predicted before any result of this edge is checked;
            // its results land behind everything already waiting.
            if (req.valid && req.ready)
                apply_request(cmd_t'(req.cmd), req.timer_id, req.timeout);
            if (rsp.valid && rsp.ready)
                check_result();
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Top of the timer bank testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on mtb_pkg, the channel
// interfaces, multi_timer_bank_unit and timer_bank_monitor.
`timescale 1ns / 1ps

module tb;
    import mtb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 2 * TIMER_COUNT + 8;

    logic clk;
    logic rst_n;

    mtb_req_if req_ch ();
    mtb_rsp_if rsp_ch ();

    int fail_count;
    int outstanding;
    int items_sent    = 0;
    int req_gap_max   = 6;
    int rsp_gap_max   = 6;
    int idle_cycles   = 0;
    bit hold_results  = 1'b0;

    multi_timer_bank_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_bank_monitor bank_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_item(input cmd_t c, input logic [ID_W-1:0] id,
                             input logic [TIMEOUT_W-1:0] to);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.timer_id <= id;
        req_ch.timeout  <= to;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic send_random_item();
        cmd_t                 c;
        logic [ID_W-1:0]      id;
        logic [TIMEOUT_W-1:0] to;
        int                   pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c = CMD_TICK;
        else if (pick < 72)
            c = CMD_SET;
        else if (pick < 86)
            c = CMD_CANCEL;
        else
            c = CMD_QUERY;
        pick = $urandom_range(0, 19);
        if (pick < 17)
            id = ID_W'($urandom_range(0, TIMER_COUNT - 1));
        else if (pick == 17)
            id = ID_W'($urandom());
        else if (pick == 18)
            id = ID_W'(TIMER_COUNT);
        else
            id = '1;
        // Long timeouts keep a timer armed for good, so they stay rare.
        pick = $urandom_range(0, 19);
        if (pick < 15)
            to = $urandom_range(0, 4);
        else if (pick < 18)
            to = $urandom_range(5, 40);
        else if (pick == 18)
            to = $urandom();
        else
            to = '1;
        send_item(c, id, to);
    endtask

    // Clears and arms every timer with one timeout, then ticks until all of
    // them fall due together, which fills one tick with results.
    task automatic run_expiry_burst();
        int                   order [TIMER_COUNT];
        int                   k;
        int                   tmp;
        logic [TIMEOUT_W-1:0] to;
        for (int i = 0; i < TIMER_COUNT; i++)
            order[i] = i;
        for (int i = TIMER_COUNT - 1; i > 0; i--)
        begin
            k        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        to = $urandom_range(0, 1);
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            send_item(CMD_CANCEL, ID_W'(order[i]), $urandom());
            send_item(CMD_SET, ID_W'(order[i]), to);
        end
        repeat (int'(to) + 1) send_item(CMD_TICK, ID_W'($urandom()), $urandom());
    endtask

    task automatic run_random(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(0, 199) < 2)
                run_expiry_burst();
            else
                send_random_item();
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: a random stall, possibly none, before each item, or one long hold on request.
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = $urandom_range(0, rsp_gap_max);
                if (gap > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multi_timer_bank_unit regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_TICK;
        req_ch.timer_id <= '0;
        req_ch.timeout  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: invalid ids, double set, cancel of an idle timer,
        // zero and maximum timeouts, a quiet tick and a deadline tie.
        send_item(CMD_QUERY, 16'd0, 32'd0);
        send_item(CMD_SET, 16'd0, 32'd0);
        send_item(CMD_SET, 16'd0, 32'd5);
        send_item(CMD_CANCEL, 16'd1, 32'd0);
        send_item(CMD_SET, ID_W'(TIMER_COUNT - 1), '1);
        send_item(CMD_QUERY, ID_W'(TIMER_COUNT - 1), 32'd0);
        send_item(CMD_SET, ID_W'(TIMER_COUNT), 32'd3);
        send_item(CMD_QUERY, 16'hFFFF, 32'd0);
        send_item(CMD_CANCEL, 16'hAAAA, 32'd0);
        send_item(CMD_QUERY, 16'h5555, 32'd0);
        send_item(CMD_TICK, 16'd0, 32'd0);
        send_item(CMD_TICK, 16'hFFFF, '1);
        send_item(CMD_SET, 16'd3, 32'd2);
        send_item(CMD_SET, 16'd4, 32'd0);
        send_item(CMD_SET, 16'd5, 32'd2);
        send_item(CMD_SET, 16'd2, 32'd1);
        send_item(CMD_CANCEL, ID_W'(TIMER_COUNT - 1), 32'd0);
        send_item(CMD_TICK, 16'd0, 32'd0);
        send_item(CMD_TICK, 16'd0, 32'd0);
        send_item(CMD_TICK, 16'd0, 32'd0);
        send_item(CMD_QUERY, 16'd0, 32'd0);
        send_item(CMD_SET, 16'd7, 32'h5555_5555);
        send_item(CMD_CANCEL, 16'd7, 32'hAAAA_AAAA);
        send_item(CMD_TICK, 16'd0, 32'd0);
        wait_drained();

        run_random(180);
        wait_drained();

        // The result side holds off while requests keep coming, so the
        // queue fills and the request channel stalls.
        hold_results = 1'b1;
        req_gap_max  = 0;
        run_expiry_burst();
        run_random(items_sent + 20);
        wait_drained();

        req_gap_max = 0;
        rsp_gap_max = 0;
        run_random(items_sent + 80);
        wait_drained();

        req_gap_max = 6;
        rsp_gap_max = 6;
        run_random(410);
        wait_drained();

        if (fail_count == 0)
            $display("multi_timer_bank_unit regression: pass");
        else
            $display("multi_timer_bank_unit regression: fail");
        $finish;
    end

endmodule
